@@ rtl/sfp_pkg.sv @@
package sfp_pkg;

    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_FUNC_HI = 3'd1,
        PH_FUNC_LO = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_LEN_LO  = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CHECK   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2,
        KIND_TIMEOUT = 2'd3
    } kind_t;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic REG_HEADER_VALUE  = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    localparam logic [7:0]  HEADER_RESET  = 8'h4A;
    localparam logic [15:0] TIMEOUT_RESET = 16'd300;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

endpackage

@@ rtl/serial_frame_parser.sv @@
// output: each result is registered and presented in the cycle after the beat that causes it is accepted
// throughput: one beat per cycle; the frame state updates in the accepting cycle
// and the result sits in an output register, so input is stalled only while
// that register is full and its own beat is stalled
// reset: rst_n asynchronous active low; waits for a header, header 0x4A, timeout 300 ticks
module serial_frame_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                mode,
    input  logic [7:0]          data_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output sfp_pkg::kind_t      kind,
    output logic [7:0]          payload_byte,
    output logic [15:0]         byte_index,
    output logic [15:0]         function_code,
    output logic [15:0]         frame_length
);
    import sfp_pkg::*;

    logic [7:0]  header_value_reg;
    logic [15:0] timeout_ticks_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] function_reg, function_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  xor_reg, xor_next;
    logic [15:0] idle_reg, idle_next;

    logic        out_valid_reg;
    kind_t       kind_reg;
    logic [7:0]  payload_byte_reg;
    logic [15:0] byte_index_reg;
    logic [15:0] function_code_reg;
    logic [15:0] frame_length_reg;

    logic        accept;
    logic        is_tick;
    logic [15:0] idle_inc;
    logic        timed_out;
    logic [15:0] count_inc;
    logic [15:0] length_full;
    logic        res_valid;
    kind_t       res_kind;
    logic [7:0]  res_byte;
    logic [15:0] res_index;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign is_tick   = (mode == MODE_TICK);
    assign idle_inc  = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 16'd1;
    assign timed_out = (phase_reg != PH_WAIT) && (idle_inc > timeout_ticks_reg);
    assign count_inc = count_reg + 16'd1;
    // length as it stands once the low byte is in
    assign length_full = {length_reg[15:8], data_byte};

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (is_tick)
        begin
            if (timed_out)
            begin
                phase_next = PH_WAIT;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_WAIT:
                begin
                    if (data_byte == header_value_reg)
                    begin
                        phase_next = PH_FUNC_HI;
                    end
                end
                PH_FUNC_HI: phase_next = PH_FUNC_LO;
                PH_FUNC_LO: phase_next = PH_LEN_HI;
                PH_LEN_HI:  phase_next = PH_LEN_LO;
                PH_LEN_LO:  phase_next = (length_full == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                PH_PAYLOAD:
                begin
                    if (count_inc >= length_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:   phase_next = PH_WAIT;
                default:    phase_next = PH_WAIT;
            endcase
        end
    end

    // frame fields and result
    always_comb
    begin
        function_next = function_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        xor_next      = xor_reg;
        idle_next     = idle_reg;
        res_valid     = 1'b0;
        res_kind      = KIND_DATA;
        res_byte      = 8'd0;
        res_index     = 16'd0;
        if (is_tick)
        begin
            idle_next = idle_inc;
            if (timed_out)
            begin
                res_valid = 1'b1;
                res_kind  = KIND_TIMEOUT;
            end
        end
        else
        begin
            idle_next = 16'd0;
            unique case (phase_reg)
                PH_WAIT:
                begin
                    if (data_byte == header_value_reg)
                    begin
                        function_next = 16'd0;
                        length_next   = 16'd0;
                        count_next    = 16'd0;
                        xor_next      = data_byte;
                    end
                end
                PH_FUNC_HI:
                begin
                    function_next = {data_byte, 8'd0};
                    xor_next      = xor_reg ^ data_byte;
                end
                PH_FUNC_LO:
                begin
                    function_next = {function_reg[15:8], data_byte};
                    xor_next      = xor_reg ^ data_byte;
                end
                PH_LEN_HI:
                begin
                    length_next = {data_byte, 8'd0};
                    xor_next    = xor_reg ^ data_byte;
                end
                PH_LEN_LO:
                begin
                    length_next = length_full;
                    xor_next    = xor_reg ^ data_byte;
                end
                PH_PAYLOAD:
                begin
                    res_valid  = 1'b1;
                    res_kind   = KIND_DATA;
                    res_byte   = data_byte;
                    res_index  = count_reg;
                    xor_next   = xor_reg ^ data_byte;
                    count_next = count_inc;
                end
                PH_CHECK:
                begin
                    res_valid = 1'b1;
                    res_kind  = (xor_reg == data_byte) ? KIND_GOOD : KIND_BAD;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_value_reg  <= HEADER_RESET;
            timeout_ticks_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEADER_VALUE:  header_value_reg  <= cfg_data[7:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_WAIT;
            function_reg <= 16'd0;
            length_reg   <= 16'd0;
            count_reg    <= 16'd0;
            xor_reg      <= 8'd0;
            idle_reg     <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            function_reg <= function_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
            xor_reg      <= xor_next;
            idle_reg     <= idle_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= res_valid;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, reported with the code and length held before this beat
    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            kind_reg          <= res_kind;
            payload_byte_reg  <= res_byte;
            byte_index_reg    <= res_index;
            function_code_reg <= function_reg;
            frame_length_reg  <= length_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign payload_byte  = payload_byte_reg;
    assign byte_index    = byte_index_reg;
    assign function_code = function_code_reg;
    assign frame_length  = frame_length_reg;

endmodule

@@ verif/sfp_checker.sv @@
module sfp_checker
    import sfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        mode,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  kind_t       kind,
    input  logic [7:0]  payload_byte,
    input  logic [15:0] byte_index,
    input  logic [15:0] function_code,
    input  logic [15:0] frame_length,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        kind_t       kind;
        logic [7:0]  pbyte;
        logic [15:0] index;
        logic [15:0] code;
        logic [15:0] length;
    } frame_report_t;

    frame_report_t due_reports[$];

    logic [7:0]  header_sel;
    logic [15:0] timeout_limit;
    phase_t      frame_phase;
    logic [15:0] code_acc;
    logic [15:0] length_acc;
    logic [15:0] payload_count;
    logic [7:0]  xor_acc;
    logic [15:0] idle_count;

    task automatic queue_report(input kind_t k, input logic [7:0] pb, input logic [15:0] idx);
        frame_report_t r;
        r.kind   = k;
        r.pbyte  = pb;
        r.index  = idx;
        r.code   = code_acc;
        r.length = length_acc;
        due_reports = {due_reports, r};
    endtask

    // advances the deframer by one beat and queues whatever it reports
    task automatic parse_beat(input logic m, input logic [7:0] b);
        if (m == MODE_TICK) begin
            if (idle_count != IDLE_MAX)
                idle_count = idle_count + 16'd1;
            if (frame_phase != PH_WAIT && idle_count > timeout_limit) begin
                queue_report(KIND_TIMEOUT, 8'h00, 16'h0000);
                frame_phase = PH_WAIT;
            end
        end
        else begin
            idle_count = 16'h0000;
            case (frame_phase)
                PH_WAIT:
                    if (b == header_sel) begin
                        code_acc      = 16'h0000;
                        length_acc    = 16'h0000;
                        payload_count = 16'h0000;
                        xor_acc       = b;
                        frame_phase   = PH_FUNC_HI;
                    end
                PH_FUNC_HI:
                begin
                    code_acc    = {b, 8'h00};
                    xor_acc     = xor_acc ^ b;
                    frame_phase = PH_FUNC_LO;
                end
                PH_FUNC_LO:
                begin
                    code_acc    = code_acc | {8'h00, b};
                    xor_acc     = xor_acc ^ b;
                    frame_phase = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    length_acc  = {b, 8'h00};
                    xor_acc     = xor_acc ^ b;
                    frame_phase = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    length_acc  = length_acc | {8'h00, b};
                    xor_acc     = xor_acc ^ b;
                    // an empty payload skips straight to the checksum
                    frame_phase = (length_acc == 16'h0000) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    queue_report(KIND_DATA, b, payload_count);
                    xor_acc       = xor_acc ^ b;
                    payload_count = payload_count + 16'd1;
                    if (payload_count >= length_acc)
                        frame_phase = PH_CHECK;
                end
                PH_CHECK:
                begin
                    queue_report((xor_acc == b) ? KIND_GOOD : KIND_BAD, 8'h00, 16'h0000);
                    frame_phase = PH_WAIT;
                end
                default:
                    frame_phase = PH_WAIT;
            endcase
        end
    endtask

    task automatic flag_field(input string field, input logic [15:0] want, input logic [15:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        mismatches++;
    endtask

    task automatic compare_report(input frame_report_t want, input frame_report_t got);
        if (got.kind !== want.kind)
            flag_field("kind", 16'(want.kind), 16'(got.kind));
        if (got.pbyte !== want.pbyte)
            flag_field("payload_byte", 16'(want.pbyte), 16'(got.pbyte));
        if (got.index !== want.index)
            flag_field("byte_index", want.index, got.index);
        if (got.code !== want.code)
            flag_field("function_code", want.code, got.code);
        if (got.length !== want.length)
            flag_field("frame_length", want.length, got.length);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_report_t seen;
        if (!rst_n) begin
            due_reports.delete();
            header_sel    = HEADER_RESET;
            timeout_limit = TIMEOUT_RESET;
            frame_phase   = PH_WAIT;
            code_acc      = 16'h0000;
            length_acc    = 16'h0000;
            payload_count = 16'h0000;
            xor_acc       = 8'h00;
            idle_count    = 16'h0000;
            mismatches    = 0;
            outstanding   = 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == REG_HEADER_VALUE)
                    header_sel = cfg_data[7:0];
                else
                    timeout_limit = cfg_data;
            end
            // results leaving now were caused by earlier beats, so match before predicting
            if (out_valid && !out_stall) begin
                seen.kind   = kind;
                seen.pbyte  = payload_byte;
                seen.index  = byte_index;
                seen.code   = function_code;
                seen.length = frame_length;
                if (due_reports.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d", $time,
                             seen.kind);
                    mismatches++;
                end
                else
                    compare_report(due_reports.pop_front(), seen);
            end
            if (in_valid && !in_stall)
                parse_beat(mode, data_byte);
            outstanding = due_reports.size();
        end
    end

endmodule

@@ verif/tb_serial_frame_parser.sv @@
module tb_serial_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import sfp_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [15:0] function_code;
    logic [15:0] frame_length;

    int mismatches;
    int outstanding;
    int cycle_count;
    int frame_beats;
    bit sender_gaps;
    bit quiet_tail;

    serial_frame_parser dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .byte_index     (byte_index),
        .function_code  (function_code),
        .frame_length   (frame_length)
    );

    sfp_checker frame_watch (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .byte_index     (byte_index),
        .function_code  (function_code),
        .frame_length   (frame_length),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("serial_frame_parser regression: fail");
        $finish;
    end

    // result side back-pressure in random bursts
    initial
    begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // starts and ends on a falling edge; valid stays high for a following beat
    task automatic send_beat(input logic m, input logic [7:0] b);
        if (sender_gaps && !quiet_tail && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_beat(MODE_TICK, 8'($urandom));
    endtask

    task automatic frame_byte(input logic [7:0] b, inout logic [7:0] sum, input int tmo);
        send_beat(MODE_BYTE, b);
        sum = sum ^ b;
        frame_beats++;
        // short silences that stay within the timeout
        if ($urandom_range(0, 5) == 0)
            send_ticks($urandom_range(0, tmo));
    endtask

    task automatic send_frame(input logic [7:0] hdr, input logic [15:0] code,
                              input logic [15:0] len, input bit corrupt, input int tmo);
        logic [7:0] sum;
        sum = 8'h00;
        frame_byte(hdr, sum, tmo);
        frame_byte(code[15:8], sum, tmo);
        frame_byte(code[7:0], sum, tmo);
        frame_byte(len[15:8], sum, tmo);
        frame_byte(len[7:0], sum, tmo);
        for (int i = 0; i < len; i++)
            frame_byte(8'($urandom), sum, tmo);
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_beat(MODE_BYTE, sum);
        frame_beats++;
    endtask

    // the block must be idle here: nothing owed and nothing still in flight
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_regs(input logic [7:0] hdr, input logic [15:0] tmo);
        cfg_we    <= 1'b1;
        cfg_index <= REG_HEADER_VALUE;
        cfg_data  <= {8'h00, hdr};
        @(negedge clk);
        cfg_index <= REG_TIMEOUT_TICKS;
        cfg_data  <= tmo;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] hdr;
        int         tmo;
        int         target;
        int         pick;
        int         len;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_HEADER_VALUE;
        cfg_data    = 16'h0000;
        in_valid    = 1'b0;
        mode        = MODE_BYTE;
        data_byte   = 8'h00;
        sender_gaps = 1'b1;
        quiet_tail  = 1'b0;
        frame_beats = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: stray byte and tick while waiting
        send_beat(MODE_BYTE, 8'h00);
        send_beat(MODE_TICK, 8'hFF);
        // all-ones code, empty payload, good checksum
        send_beat(MODE_BYTE, 8'h4A);
        send_beat(MODE_BYTE, 8'hFF);
        send_beat(MODE_BYTE, 8'hFF);
        send_beat(MODE_BYTE, 8'h00);
        send_beat(MODE_BYTE, 8'h00);
        send_beat(MODE_BYTE, 8'h4A);
        // two payload bytes with a tick between them, checksum off by one bit
        send_beat(MODE_BYTE, 8'h4A);
        send_beat(MODE_BYTE, 8'h00);
        send_beat(MODE_BYTE, 8'h00);
        send_beat(MODE_BYTE, 8'h00);
        send_beat(MODE_BYTE, 8'h02);
        send_beat(MODE_BYTE, 8'hFF);
        send_beat(MODE_TICK, 8'h00);
        send_beat(MODE_BYTE, 8'h00);
        send_beat(MODE_BYTE, 8'hB6);

        // zero timeout: the first tick inside a frame aborts it
        drain(4);
        write_regs(8'h00, 16'h0000);
        send_beat(MODE_BYTE, 8'h00);
        send_beat(MODE_BYTE, 8'h12);
        send_beat(MODE_TICK, 8'h00);
        send_beat(MODE_TICK, 8'h00);

        // largest timeout: a long silence inside a frame never trips it
        drain(4);
        write_regs(8'hFF, 16'hFFFF);
        send_beat(MODE_BYTE, 8'hFF);
        send_beat(MODE_BYTE, 8'hA5);
        sender_gaps = 1'b0;
        send_ticks(40);
        sender_gaps = 1'b1;
        send_beat(MODE_BYTE, 8'h5A);
        send_beat(MODE_BYTE, 8'h00);
        send_beat(MODE_BYTE, 8'h01);
        send_beat(MODE_BYTE, 8'h80);
        send_beat(MODE_BYTE, 8'h81);

        frame_beats = 0;
        while (frame_beats < 330) begin
            drain(4);
            if (frame_beats >= 270)
                quiet_tail = 1'b1;
            hdr = 8'($urandom);
            tmo = $urandom_range(0, 12);
            write_regs(hdr, 16'(tmo));
            target = frame_beats + 55;
            while (frame_beats < target) begin
                pick = $urandom_range(0, 19);
                if (pick < 14) begin
                    len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40)
                                                       : $urandom_range(0, 6);
                    send_frame(hdr, 16'($urandom), 16'(len), pick < 2, tmo);
                end
                else if (pick < 17) begin
                    // cut-off frame left to time out
                    send_beat(MODE_BYTE, hdr);
                    frame_beats++;
                    repeat ($urandom_range(0, 6)) begin
                        send_beat(MODE_BYTE, 8'($urandom));
                        frame_beats++;
                    end
                    send_ticks(tmo + 1 + $urandom_range(0, 3));
                end
                else
                    repeat ($urandom_range(1, 4)) send_beat(1'($urandom), 8'($urandom));
            end
        end

        drain(5);
        if (mismatches == 0)
            $display("serial_frame_parser regression: pass");
        else
            $display("serial_frame_parser regression: fail");
        $finish;
    end

endmodule
